>>> sv/lri_pkg.sv
// Shared types, widths and helpers for the line/rectangle intersection core.
package lri_pkg;

	localparam int FRAC_W = 16;
	localparam int DIV_W  = 47;
	localparam int DEN_W  = 16;
	localparam logic [40:0] FAR_SCALE = 41'd100;
	localparam logic [40:0] FAR_LIMIT = 41'h100000000;

	typedef struct packed {
		logic signed [15:0] rect_left_x;
		logic signed [15:0] rect_bottom_y;
		logic signed [15:0] rect_right_x;
		logic signed [15:0] rect_top_y;
		logic signed [31:0] line_base_x;
		logic signed [31:0] line_base_y;
		logic signed [15:0] line_dir_x;
		logic signed [15:0] line_dir_y;
	} line_item_t;

	typedef struct packed {
		logic               found;
		logic signed [15:0] first_x;
		logic signed [15:0] first_y;
		logic signed [15:0] second_x;
		logic signed [15:0] second_y;
	} hit_item_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
	} pt_t;

	function automatic logic [15:0] to_pix(logic signed [31:0] q);
		logic [15:0] hi;
		hi = q[31:16];
		if (q[31] && (q[15:0] != 16'h0))
			hi = hi + 16'd1;
		return hi;
	endfunction

endpackage

>>> sv/lri_div_pipe.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
module lri_div_pipe (
	input  logic                        clk,
	input  logic                        en,
	input  logic [lri_pkg::DIV_W-1:0]   dividend,
	input  logic [lri_pkg::DEN_W-1:0]   divisor,
	output logic [lri_pkg::DIV_W-1:0]   quotient
);
	import lri_pkg::*;

	logic [DIV_W-1:0] rq_q  [DIV_W];
	logic [DEN_W-1:0] rem_q [DIV_W];
	logic [DEN_W-1:0] dv_q  [DIV_W];

	genvar i;
	generate
		for (i = 0; i < DIV_W; i++) begin : g_st
			logic [DIV_W-1:0] rq_in;
			logic [DEN_W-1:0] rem_in;
			logic [DEN_W-1:0] dv_in;
			logic [DEN_W:0]   trial;
			logic [DEN_W:0]   diff;
			logic             ge;
			if (i == 0) begin : g_first
				assign rq_in  = dividend;
				assign rem_in = '0;
				assign dv_in  = divisor;
			end else begin : g_next
				assign rq_in  = rq_q[i-1];
				assign rem_in = rem_q[i-1];
				assign dv_in  = dv_q[i-1];
			end
			assign trial = {rem_in, rq_in[DIV_W-1]};
			assign diff  = trial - {1'b0, dv_in};
			assign ge    = trial >= {1'b0, dv_in};
			always_ff @(posedge clk) begin
				if (en) begin
					rq_q[i]  <= {rq_in[DIV_W-2:0], ge};
					rem_q[i] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
					dv_q[i]  <= dv_in;
				end
			end
		end
	endgenerate

	assign quotient = rq_q[DIV_W-1];

endmodule

>>> sv/lri_far_chk.sv
// Three-stage check that two Q16.16 points lie more than 0.1 apart.
module lri_far_chk (
	input  logic         clk,
	input  logic         en,
	input  lri_pkg::pt_t a,
	input  lri_pkg::pt_t b,
	output logic         far
);
	import lri_pkg::*;

	logic signed [32:0] dx, dy;
	logic [32:0]        adx, ady;
	logic               big_s1, big_s2, far_s3;
	logic [15:0]        ex_s1, ey_s1;
	logic [31:0]        sqx_s2, sqy_s2;
	logic [32:0]        sum;

	assign dx  = 33'(a.x) - 33'(b.x);
	assign dy  = 33'(a.y) - 33'(b.y);
	assign adx = dx[32] ? 33'(-dx) : 33'(dx);
	assign ady = dy[32] ? 33'(-dy) : 33'(dy);
	assign sum = 33'(sqx_s2) + 33'(sqy_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			big_s1 <= (|adx[32:FRAC_W]) || (|ady[32:FRAC_W]);
			ex_s1  <= adx[15:0];
			ey_s1  <= ady[15:0];
			big_s2 <= big_s1;
			sqx_s2 <= ex_s1 * ex_s1;
			sqy_s2 <= ey_s1 * ey_s1;
			far_s3 <= big_s2 || ((41'(sum) * FAR_SCALE) > FAR_LIMIT);
		end
	end

	assign far = far_s3;

endmodule

>>> sv/line_rect_intersection_core.sv
// Top level: line versus axis-aligned rectangle intersection pipeline.
//
// channel  dir  valid       stall       payload
// line     in   line_valid  line_stall  line_item (lri_pkg::line_item_t)
// hit      out  hit_valid   hit_stall   hit_item  (lri_pkg::hit_item_t)
//
// One item per cycle unless the pipeline is stalled; most of its depth is in the 47-stage dividers.
// Whole pipeline holds while hit_valid is high and hit_stall is high.
// arst_n clears only valid bits; payload registers are not reset.
module line_rect_intersection_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                line_valid,
	output logic                line_stall,
	input  lri_pkg::line_item_t line_item,
	output logic                hit_valid,
	input  logic                hit_stall,
	output lri_pkg::hit_item_t  hit_item
);
	import lri_pkg::*;

	typedef struct packed {
		logic signed [15:0] left;
		logic signed [15:0] bottom;
		logic signed [15:0] right;
		logic signed [15:0] top;
		logic signed [31:0] base_x;
		logic signed [31:0] base_y;
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
		logic [3:0]         neg;
	} side_t;

	typedef struct packed {
		logic [3:0]         hit;
		pt_t [3:0]          pt;
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
	} hit_t;

	typedef struct packed {
		logic [1:0]         n;
		pt_t                p0;
		pt_t                p1;
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
	} sel_t;

	logic adv;

	// s1
	line_item_t item_s1;
	logic       v_s1;
	// s2
	logic signed [48:0] prod_s2 [4];
	side_t              side_s2;
	logic               v_s2;
	// s3
	logic [DIV_W-1:0]   mag_s3 [4];
	logic [DEN_W-1:0]   den_s3 [4];
	side_t              side_s3;
	logic               v_s3;
	// divider sideband
	side_t              side_q [DIV_W];
	logic [DIV_W-1:0]   vd_q;
	logic [DIV_W-1:0]   quot [4];
	// s4, s5
	logic signed [49:0] coord_s4 [4];
	side_t              side_s4;
	logic               v_s4;
	hit_t               hit_s5;
	logic               v_s5;
	// far delay
	hit_t               hd_q [3];
	logic [2:0]         vh_q;
	logic [2:0]         far_o;
	// s9..s11
	sel_t               sel_s9, sel_s10;
	logic               v_s9, v_s10, v_s11;
	logic signed [48:0] dotx_s10, doty_s10;
	hit_item_t          out_s11;

	assign adv        = !v_s11 || !hit_stall;
	assign line_stall = !adv;
	assign hit_valid  = v_s11;
	assign hit_item   = out_s11;

	// s1 -> s2: numerators times cross direction
	logic signed [32:0] num [4];
	logic signed [48:0] prod [4];
	side_t              side_c;

	always_comb begin
		num[0] = 33'($signed({item_s1.rect_left_x, 16'h0}))   - 33'(item_s1.line_base_x);
		num[1] = 33'($signed({item_s1.rect_right_x, 16'h0}))  - 33'(item_s1.line_base_x);
		num[2] = 33'($signed({item_s1.rect_bottom_y, 16'h0})) - 33'(item_s1.line_base_y);
		num[3] = 33'($signed({item_s1.rect_top_y, 16'h0}))    - 33'(item_s1.line_base_y);
		prod[0] = 49'(num[0]) * 49'(item_s1.line_dir_y);
		prod[1] = 49'(num[1]) * 49'(item_s1.line_dir_y);
		prod[2] = 49'(num[2]) * 49'(item_s1.line_dir_x);
		prod[3] = 49'(num[3]) * 49'(item_s1.line_dir_x);
		side_c.left   = item_s1.rect_left_x;
		side_c.bottom = item_s1.rect_bottom_y;
		side_c.right  = item_s1.rect_right_x;
		side_c.top    = item_s1.rect_top_y;
		side_c.base_x = item_s1.line_base_x;
		side_c.base_y = item_s1.line_base_y;
		side_c.dir_x  = item_s1.line_dir_x;
		side_c.dir_y  = item_s1.line_dir_y;
		side_c.neg    = '0;
	end

	// s2 -> s3: sign-magnitude split
	logic [15:0] adir_x, adir_y;
	logic [48:0] pmag [4];
	logic [3:0]  neg_c;
	side_t       side_n;

	assign adir_x = side_s2.dir_x[15] ? 16'(-side_s2.dir_x) : 16'(side_s2.dir_x);
	assign adir_y = side_s2.dir_y[15] ? 16'(-side_s2.dir_y) : 16'(side_s2.dir_y);

	always_comb begin
		for (int k = 0; k < 4; k++)
			pmag[k] = prod_s2[k][48] ? 49'(-prod_s2[k]) : 49'(prod_s2[k]);
		neg_c[0] = prod_s2[0][48] ^ side_s2.dir_x[15];
		neg_c[1] = prod_s2[1][48] ^ side_s2.dir_x[15];
		neg_c[2] = prod_s2[2][48] ^ side_s2.dir_y[15];
		neg_c[3] = prod_s2[3][48] ^ side_s2.dir_y[15];
		side_n     = side_s2;
		side_n.neg = neg_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			vd_q  <= '0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			vh_q  <= '0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
		end else if (adv) begin
			v_s1  <= line_valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			vd_q  <= {vd_q[DIV_W-2:0], v_s3};
			v_s4  <= vd_q[DIV_W-1];
			v_s5  <= v_s4;
			vh_q  <= {vh_q[1:0], v_s5};
			v_s9  <= vh_q[2];
			v_s10 <= v_s9;
			v_s11 <= v_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1 <= line_item;
			for (int k = 0; k < 4; k++)
				prod_s2[k] <= prod[k];
			side_s2 <= side_c;
			for (int k = 0; k < 2; k++) begin
				mag_s3[k]   <= pmag[k][DIV_W-1:0];
				den_s3[k]   <= adir_x;
				mag_s3[k+2] <= pmag[k+2][DIV_W-1:0];
				den_s3[k+2] <= adir_y;
			end
			side_s3 <= side_n;
		end
	end

	genvar g;
	generate
		for (g = 0; g < 4; g++) begin : g_div
			lri_div_pipe u_div (
				.clk      (clk),
				.en       (adv),
				.dividend (mag_s3[g]),
				.divisor  (den_s3[g]),
				.quotient (quot[g])
			);
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (adv) begin
			side_q[0] <= side_s3;
			for (int i = 1; i < DIV_W; i++)
				side_q[i] <= side_q[i-1];
		end
	end

	// s4: add base
	side_t              sd;
	logic signed [49:0] qs [4];

	assign sd = side_q[DIV_W-1];

	always_comb begin
		for (int k = 0; k < 4; k++)
			qs[k] = sd.neg[k] ? -50'({3'b0, quot[k]}) : 50'({3'b0, quot[k]});
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			coord_s4[0] <= qs[0] + 50'(sd.base_y);
			coord_s4[1] <= qs[1] + 50'(sd.base_y);
			coord_s4[2] <= qs[2] + 50'(sd.base_x);
			coord_s4[3] <= qs[3] + 50'(sd.base_x);
			side_s4     <= sd;
		end
	end

	// s5: bounds
	logic signed [31:0] lq, rq, bq, tq;
	hit_t               hit_c;

	always_comb begin
		lq = $signed({side_s4.left, 16'h0});
		rq = $signed({side_s4.right, 16'h0});
		bq = $signed({side_s4.bottom, 16'h0});
		tq = $signed({side_s4.top, 16'h0});
		hit_c.hit[0] = (side_s4.dir_x != 16'sd0) &&
			(coord_s4[0] >= 50'(bq)) && (coord_s4[0] <= 50'(tq));
		hit_c.hit[1] = (side_s4.dir_x != 16'sd0) &&
			(coord_s4[1] >= 50'(bq)) && (coord_s4[1] <= 50'(tq));
		hit_c.hit[2] = (side_s4.dir_y != 16'sd0) &&
			(coord_s4[2] >= 50'(lq)) && (coord_s4[2] <= 50'(rq));
		hit_c.hit[3] = (side_s4.dir_y != 16'sd0) &&
			(coord_s4[3] >= 50'(lq)) && (coord_s4[3] <= 50'(rq));
		hit_c.pt[0].x = lq;
		hit_c.pt[0].y = coord_s4[0][31:0];
		hit_c.pt[1].x = rq;
		hit_c.pt[1].y = coord_s4[1][31:0];
		hit_c.pt[2].x = coord_s4[2][31:0];
		hit_c.pt[2].y = bq;
		hit_c.pt[3].x = coord_s4[3][31:0];
		hit_c.pt[3].y = tq;
		hit_c.dir_x   = side_s4.dir_x;
		hit_c.dir_y   = side_s4.dir_y;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hit_s5   <= hit_c;
			hd_q[0]  <= hit_s5;
			hd_q[1]  <= hd_q[0];
			hd_q[2]  <= hd_q[1];
		end
	end

	// distance checks: first side hit vs bottom, vs top; bottom vs top
	pt_t pa;

	assign pa = hit_s5.hit[0] ? hit_s5.pt[0] : hit_s5.pt[1];

	lri_far_chk u_far_ab (.clk(clk), .en(adv), .a(pa), .b(hit_s5.pt[2]), .far(far_o[0]));
	lri_far_chk u_far_at (.clk(clk), .en(adv), .a(pa), .b(hit_s5.pt[3]), .far(far_o[1]));
	lri_far_chk u_far_bt (.clk(clk), .en(adv), .a(hit_s5.pt[2]), .b(hit_s5.pt[3]),
		.far(far_o[2]));

	// s9: keep rules and point selection
	hit_t       hd;
	logic [1:0] n_lr, n_b;
	logic       keep_b, keep_t;
	sel_t       sel_c;

	assign hd = hd_q[2];

	always_comb begin
		n_lr   = 2'(hd.hit[0]) + 2'(hd.hit[1]);
		keep_b = hd.hit[2] && ((n_lr == 2'd0) || ((n_lr == 2'd1) && far_o[0]));
		n_b    = n_lr + 2'(keep_b);
		keep_t = hd.hit[3] && ((n_b == 2'd0) ||
			((n_b == 2'd1) && ((n_lr == 2'd1) ? far_o[1] : far_o[2])));
		sel_c.n     = n_b + 2'(keep_t);
		sel_c.dir_x = hd.dir_x;
		sel_c.dir_y = hd.dir_y;
		priority if (hd.hit[0])
			sel_c.p0 = hd.pt[0];
		else if (hd.hit[1])
			sel_c.p0 = hd.pt[1];
		else if (keep_b)
			sel_c.p0 = hd.pt[2];
		else
			sel_c.p0 = hd.pt[3];
		priority if (hd.hit[0] && hd.hit[1])
			sel_c.p1 = hd.pt[1];
		else if ((hd.hit[0] || hd.hit[1]) && keep_b)
			sel_c.p1 = hd.pt[2];
		else if (n_b != 2'd0)
			sel_c.p1 = hd.pt[3];
		else
			sel_c.p1 = sel_c.p0;
	end

	// s10: direction products; s11: order and truncate
	logic signed [32:0] dpx, dpy;
	logic signed [49:0] dot;
	logic               pos;
	logic [15:0]        ax, ay, bx, by;
	hit_item_t          out_c;

	assign dpx = 33'(sel_s9.p1.x) - 33'(sel_s9.p0.x);
	assign dpy = 33'(sel_s9.p1.y) - 33'(sel_s9.p0.y);
	assign dot = 50'(dotx_s10) + 50'(doty_s10);
	assign pos = dot > 50'sd0;

	always_comb begin
		ax = to_pix(sel_s10.p0.x);
		ay = to_pix(sel_s10.p0.y);
		bx = to_pix(sel_s10.p1.x);
		by = to_pix(sel_s10.p1.y);
		unique case (sel_s10.n)
			2'd0: out_c = '0;
			2'd1: out_c = '{1'b1, ax, ay, ax, ay};
			default: out_c = pos ? '{1'b1, ax, ay, bx, by} : '{1'b1, bx, by, ax, ay};
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sel_s9   <= sel_c;
			sel_s10  <= sel_s9;
			dotx_s10 <= 49'(dpx) * 49'(sel_s9.dir_x);
			doty_s10 <= 49'(dpy) * 49'(sel_s9.dir_y);
			out_s11  <= out_c;
		end
	end

`ifndef SYNTHESIS
	a_nohit_zero: assert property (@(posedge clk) disable iff (!arst_n)
		hit_valid && !hit_item.found |-> hit_item.first_x == 16'sd0 &&
		hit_item.first_y == 16'sd0 && hit_item.second_x == 16'sd0 &&
		hit_item.second_y == 16'sd0)
		else $error("no-hit item carries nonzero coordinates");
	a_side_pair_full: assert property (@(posedge clk) disable iff (!arst_n)
		vh_q[2] && hd.hit[0] && hd.hit[1] |-> !keep_b && !keep_t)
		else $error("third hit kept after both side edges");
	a_flat_x: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && hit_s5.dir_x == 16'sd0 |-> !hit_s5.hit[0] && !hit_s5.hit[1])
		else $error("side edge hit with zero x direction");
`endif

endmodule

>>> tb/tb_line_rect_intersection_core.sv
// Testbench for line_rect_intersection_core: directed table and random lines, checked in order.
`timescale 1ns / 100ps

module tb_line_rect_intersection_core;
	import lri_pkg::*;

	localparam int HOLD_START   = 500;
	localparam int HOLD_CYCLES  = 300;
	localparam int QUIET_START  = 1200;
	localparam int QUIET_CYCLES = 500;
	localparam int WATCH_LIMIT  = 4000;
	localparam int N_RANDOM     = 1800;
	localparam int DRAIN_CYCLES = 70;

	typedef struct {
		line_item_t line;
		bit         typed;
		hit_item_t  hit;
	} line_row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       line_valid = 1'b0;
	logic       line_stall;
	line_item_t line_item = '0;
	logic       hit_valid;
	logic       hit_stall = 1'b0;
	hit_item_t  hit_item;

	hit_item_t  pending_hits[$];
	int         mismatches = 0;
	int         idle_cycles = 0;
	int         cycle_no = 0;
	bit         quiet_driver = 1'b0;

	line_rect_intersection_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.line_valid(line_valid),
		.line_stall(line_stall),
		.line_item (line_item),
		.hit_valid (hit_valid),
		.hit_stall (hit_stall),
		.hit_item  (hit_item)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic longint abs64(longint v);
		return (v < 0) ? -v : v;
	endfunction

	// more than 0.1 apart, Q16.16 points
	function automatic bit points_far(longint ax, longint ay, longint bx, longint by);
		longint dx;
		longint dy;
		dx = abs64(ax - bx);
		dy = abs64(ay - by);
		if (dx >= 65536 || dy >= 65536)
			return 1'b1;
		return ((dx * dx + dy * dy) * 100) > (64'd1 << 32);
	endfunction

	function automatic logic [15:0] q_to_pix(longint q);
		longint p;
		p = q / 65536;
		return p[15:0];
	endfunction

	function automatic hit_item_t predict_hit(line_item_t it);
		longint lq, bq, rq, tq, bx, by, dx, dy, v, e, dot;
		longint px[2];
		longint py[2];
		int n;
		int a;
		hit_item_t h;
		lq = longint'(it.rect_left_x) * 65536;
		bq = longint'(it.rect_bottom_y) * 65536;
		rq = longint'(it.rect_right_x) * 65536;
		tq = longint'(it.rect_top_y) * 65536;
		bx = longint'(it.line_base_x);
		by = longint'(it.line_base_y);
		dx = longint'(it.line_dir_x);
		dy = longint'(it.line_dir_y);
		n = 0;
		px[0] = 0; px[1] = 0; py[0] = 0; py[1] = 0;
		if (dx != 0) begin
			for (int k = 0; k < 2; k++) begin
				e = (k == 0) ? lq : rq;
				v = by + ((e - bx) * dy) / dx;
				if (v >= bq && v <= tq) begin
					px[n] = e;
					py[n] = v;
					n++;
				end
			end
		end
		if (dy != 0) begin
			for (int k = 0; k < 2; k++) begin
				e = (k == 0) ? bq : tq;
				v = bx + ((e - by) * dx) / dy;
				if (v >= lq && v <= rq && n < 2) begin
					if (n == 0 || points_far(px[0], py[0], v, e)) begin
						px[n] = v;
						py[n] = e;
						n++;
					end
				end
			end
		end
		h = '0;
		if (n == 1) begin
			h.found = 1'b1;
			h.first_x = q_to_pix(px[0]);
			h.first_y = q_to_pix(py[0]);
			h.second_x = h.first_x;
			h.second_y = h.first_y;
		end else if (n == 2) begin
			dot = (px[1] - px[0]) * dx + (py[1] - py[0]) * dy;
			a = (dot > 0) ? 0 : 1;
			h.found = 1'b1;
			h.first_x = q_to_pix(px[a]);
			h.first_y = q_to_pix(py[a]);
			h.second_x = q_to_pix(px[1 - a]);
			h.second_y = q_to_pix(py[1 - a]);
		end
		return h;
	endfunction

	function automatic line_item_t random_line();
		line_item_t it;
		int cx, cy, w, hgt;
		if ($urandom_range(99) < 12) begin
			it = {$urandom, $urandom, $urandom, $urandom, $urandom};
			return it;
		end
		cx = $urandom_range(65535) - 32768;
		cy = $urandom_range(65535) - 32768;
		if ($urandom_range(3) == 0) begin
			cx = $urandom_range(200) - 100;
			cy = $urandom_range(200) - 100;
		end
		w = $urandom_range(40);
		hgt = $urandom_range(40);
		if (cx + w > 32767) cx = 32767 - w;
		if (cy + hgt > 32767) cy = 32767 - hgt;
		it.rect_left_x = 16'(cx);
		it.rect_bottom_y = 16'(cy);
		it.rect_right_x = 16'(cx + w);
		it.rect_top_y = 16'(cy + hgt);
		if ($urandom_range(19) == 0) begin
			it.rect_left_x = 16'(cx + w);
			it.rect_right_x = 16'(cx);
		end
		it.line_base_x = 32'((cx + $urandom_range(w)) * 65536) + 32'($urandom_range(65535));
		it.line_base_y = 32'((cy + $urandom_range(hgt)) * 65536) + 32'($urandom_range(65535));
		if ($urandom_range(4) == 0)
			it.line_base_x = it.line_base_x + 32'($urandom_range(4000000) - 2000000);
		it.line_dir_x = 16'($urandom);
		it.line_dir_y = 16'($urandom);
		case ($urandom_range(7))
			0: it.line_dir_x = '0;
			1: it.line_dir_y = '0;
			2: it.line_dir_y = it.line_dir_x;
			3: it.line_dir_y = -it.line_dir_x;
			default: ;
		endcase
		return it;
	endfunction

	task automatic send_line(line_item_t it);
		if (!quiet_driver) begin
			while ($urandom_range(99) < 9) begin
				line_valid <= 1'b0;
				@(posedge clk);
			end
		end
		line_item <= it;
		line_valid <= 1'b1;
		do @(posedge clk); while (line_stall);
		pending_hits.push_back(predict_hit(it));
	endtask

	task automatic report(hit_item_t want, hit_item_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch: expected %0b %0d,%0d %0d,%0d got %0b %0d,%0d %0d,%0d",
				want.found, want.first_x, want.first_y, want.second_x, want.second_y,
				got.found, got.first_x, got.first_y, got.second_x, got.second_y);
	endtask

	// stimulus
	initial begin
		line_row_t rows[$];
		line_row_t r;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		r.typed = 1'b1;
		r.line = '{0, 0, 10, 10, 0, 0, 0, 0};
		r.hit = '0; rows.push_back(r);
		r.line = '{0, 0, 10, 10, 131072, 327680, 16384, 0};
		r.hit = '{1, 0, 5, 10, 5}; rows.push_back(r);
		r.line = '{0, 0, 10, 10, 131072, 327680, -16384, 0};
		r.hit = '{1, 10, 5, 0, 5}; rows.push_back(r);
		r.line = '{0, 0, 10, 10, 196608, 131072, 0, 16384};
		r.hit = '{1, 3, 0, 3, 10}; rows.push_back(r);
		r.line = '{10, 10, 0, 0, 131072, 327680, 16384, 0};
		r.hit = '0; rows.push_back(r);
		r.typed = 1'b0;
		r.line = '{10, 0, 0, 10, 131072, 327680, 16384, 0}; rows.push_back(r);
		r.line = '{0, 0, 10, 10, 0, 0, 16384, 16384}; rows.push_back(r);
		r.line = '{0, 0, 10, 10, 0, 0, -16384, -16384}; rows.push_back(r);
		r.line = '{0, 0, 10, 10, 0, 655360, 16384, 0}; rows.push_back(r);
		r.line = '{0, 0, 10, 10, 0, 655360, 16384, 16384}; rows.push_back(r);
		r.line = '{5, 5, 5, 5, 327680, 327680, 1, 1}; rows.push_back(r);
		r.line = '{4, 4, 4, 9, 327680, 327680, 0, -1}; rows.push_back(r);
		r.line = '{-10, -10, -1, -1, -327680, -98304, 16384, 3}; rows.push_back(r);
		r.line = '{-10, -10, -1, -1, -32769, -327681, -3, -16384}; rows.push_back(r);
		r.line = '{-32768, -32768, 32767, 32767, 32'h7fffffff, 32'h80000000,
			-32768, 32767}; rows.push_back(r);
		r.line = '{-32768, -32768, 32767, 32767, 32'h80000000, 32'h7fffffff,
			32767, -32768}; rows.push_back(r);
		r.line = '{-32768, -32768, 32767, 32767, 0, 0, 1, -32768}; rows.push_back(r);
		r.line = '{32767, 32767, -32768, -32768, 0, 0, 100, 100}; rows.push_back(r);
		r.line = '{0, 0, 0, 0, 0, 0, 16384, 16384}; rows.push_back(r);
		r.line = '{0, 0, 10, 10, 6554, 0, 16384, 16384}; rows.push_back(r);
		r.line = '{0, 0, 10, 10, 6553, 0, 16384, 16384}; rows.push_back(r);

		foreach (rows[i]) begin
			send_line(rows[i].line);
			if (rows[i].typed) begin
				void'(pending_hits.pop_back());
				pending_hits.push_back(rows[i].hit);
			end
		end
		for (int i = 0; i < N_RANDOM; i++) begin
			quiet_driver = (i >= 1000 && i < 1400);
			send_line(random_line());
		end
		line_valid <= 1'b0;
		while (pending_hits.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("** line_rect_intersection_core: PASSED **");
		else
			$display("** line_rect_intersection_core: FAILED **");
		$finish;
	end

	// receiver stall
	always @(posedge clk) begin
		cycle_no <= cycle_no + 1;
		if (cycle_no >= HOLD_START && cycle_no < HOLD_START + HOLD_CYCLES)
			hit_stall <= 1'b1;
		else if (cycle_no >= QUIET_START && cycle_no < QUIET_START + QUIET_CYCLES)
			hit_stall <= 1'b0;
		else
			hit_stall <= ($urandom_range(99) < 9);
	end

	// checker and watchdog
	always @(posedge clk) begin
		hit_item_t want;
		if (arst_n && hit_valid && !hit_stall) begin
			if (pending_hits.size() == 0) begin
				report('0, hit_item);
			end else begin
				want = pending_hits.pop_front();
				if (hit_item.found !== want.found || hit_item.first_x !== want.first_x
					|| hit_item.first_y !== want.first_y
					|| hit_item.second_x !== want.second_x
					|| hit_item.second_y !== want.second_y)
					report(want, hit_item);
			end
		end
		if ((hit_valid && !hit_stall) || (line_valid && !line_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCH_LIMIT) begin
			$display("** line_rect_intersection_core: FAILED **");
			$finish;
		end
	end

endmodule
